// ===== sv/pgfe_pkg.sv =====
// Shared types, widths and register codes for the phi4 gradient free energy block.
// No dependencies; every other file in the project but pgfe_delay uses this package.
package pgfe_pkg;

	localparam int DATA_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 24;

	localparam int OUT_BITS  = 48;
	localparam int SUM_BITS  = 52;
	localparam int HALF_W    = OUT_BITS / 2;
	localparam int PROD_BITS = 2 * OUT_BITS;

	// pipeline register stages from request to the output buffer push
	localparam int PIPE_DEPTH = 11;
	localparam int OBUF_DEPTH = 2;

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_KAPPA = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_C     = 2'd3;

	typedef logic signed [OUT_BITS-1:0] out_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

	typedef struct packed {
		out_t free_energy_density;
		out_t chemical_potential;
		out_t stress_xx;
		out_t stress_yy;
		out_t stress_zz;
		out_t stress_xy;
		out_t stress_xz;
		out_t stress_yz;
	} res_t;

	localparam int RES_BITS = $bits(res_t);

	// Clamp an exact wide sum to the signed result range.
	function automatic out_t sat_out(input sum_t v);
		sum_t hi;
		sum_t lo;
		hi = {{(SUM_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat_out = hi[OUT_BITS-1:0];
		end else if (v < lo) begin
			sat_out = lo[OUT_BITS-1:0];
		end else begin
			sat_out = v[OUT_BITS-1:0];
		end
	endfunction

endpackage

// ===== sv/pgfe_if.sv =====
// Request, result and configuration channels (valid/ready) of the block.
// Depends on pgfe_pkg for widths and the result field type.
interface pgfe_in_if #(parameter int DATA_BITS = pgfe_pkg::DATA_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] phi_value;
	logic signed [DATA_BITS-1:0] grad_x;
	logic signed [DATA_BITS-1:0] grad_y;
	logic signed [DATA_BITS-1:0] grad_z;
	logic signed [DATA_BITS-1:0] lap_phi;
	logic signed [DATA_BITS-1:0] bilap_phi;
	logic signed [DATA_BITS-1:0] grad_lap_x;
	logic signed [DATA_BITS-1:0] grad_lap_y;
	logic signed [DATA_BITS-1:0] grad_lap_z;

	modport source (output valid, phi_value, grad_x, grad_y, grad_z, lap_phi, bilap_phi,
		grad_lap_x, grad_lap_y, grad_lap_z, input ready);
	modport sink (input valid, phi_value, grad_x, grad_y, grad_z, lap_phi, bilap_phi,
		grad_lap_x, grad_lap_y, grad_lap_z, output ready);
endinterface

interface pgfe_out_if;
	import pgfe_pkg::*;
	logic valid;
	logic ready;
	out_t free_energy_density;
	out_t chemical_potential;
	out_t stress_xx;
	out_t stress_yy;
	out_t stress_zz;
	out_t stress_xy;
	out_t stress_xz;
	out_t stress_yz;

	modport source (output valid, free_energy_density, chemical_potential, stress_xx,
		stress_yy, stress_zz, stress_xy, stress_xz, stress_yz, input ready);
	modport sink (input valid, free_energy_density, chemical_potential, stress_xx,
		stress_yy, stress_zz, stress_xy, stress_xz, stress_yz, output ready);
endinterface

interface pgfe_cfg_if #(parameter int DATA_BITS = pgfe_pkg::DATA_BITS_DEF);
	import pgfe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pgfe_mulq.sv =====
// Two-stage rounded, saturating fixed-point multiplier on 48-bit signed operands.
// Stage 1 forms four half-width partial products; stage 2 sums, rounds, clamps.
// Depends on pgfe_pkg.
module pgfe_mulq #(
	parameter int FRAC_BITS = pgfe_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  pgfe_pkg::out_t op_a,
	input  pgfe_pkg::out_t op_b,
	output pgfe_pkg::out_t prod
);
	import pgfe_pkg::*;

	logic [OUT_BITS-1:0]  mag_a;
	logic [OUT_BITS-1:0]  mag_b;
	logic                 neg_s1;
	logic [2*HALF_W-1:0]  ll_s1;
	logic [2*HALF_W-1:0]  lh_s1;
	logic [2*HALF_W-1:0]  hl_s1;
	logic [2*HALF_W-1:0]  hh_s1;
	logic [PROD_BITS-1:0] full_p;
	logic [PROD_BITS-1:0] rnd_p;
	logic [PROD_BITS-1:0] mag_p;
	logic [PROD_BITS-1:0] limit;
	logic [PROD_BITS-1:0] clip_p;
	logic [OUT_BITS-1:0]  mag_r;
	out_t                 res;
	out_t                 prod_s2;

	assign mag_a = op_a[OUT_BITS-1] ? ~op_a + 1'b1 : op_a;
	assign mag_b = op_b[OUT_BITS-1] ? ~op_b + 1'b1 : op_b;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= op_a[OUT_BITS-1] ^ op_b[OUT_BITS-1];
			ll_s1  <= OUT_BITS'(mag_a[HALF_W-1:0]) * OUT_BITS'(mag_b[HALF_W-1:0]);
			lh_s1  <= OUT_BITS'(mag_a[HALF_W-1:0]) * OUT_BITS'(mag_b[OUT_BITS-1:HALF_W]);
			hl_s1  <= OUT_BITS'(mag_a[OUT_BITS-1:HALF_W]) * OUT_BITS'(mag_b[HALF_W-1:0]);
			hh_s1  <= OUT_BITS'(mag_a[OUT_BITS-1:HALF_W])
				* OUT_BITS'(mag_b[OUT_BITS-1:HALF_W]);
		end
	end

	always_comb begin
		full_p = {hh_s1, ll_s1} + (PROD_BITS'(lh_s1) << HALF_W)
			+ (PROD_BITS'(hl_s1) << HALF_W);
		// round half away from zero on the magnitude
		rnd_p  = full_p + (PROD_BITS'(1) << (FRAC_BITS - 1));
		mag_p  = rnd_p >> FRAC_BITS;
		limit  = neg_s1 ? (PROD_BITS'(1) << (OUT_BITS - 1))
			: (PROD_BITS'(1) << (OUT_BITS - 1)) - PROD_BITS'(1);
		clip_p = (mag_p > limit) ? limit : mag_p;
		mag_r  = clip_p[OUT_BITS-1:0];
		res    = neg_s1 ? out_t'(~mag_r + 1'b1) : out_t'(mag_r);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= res;
		end
	end

	assign prod = prod_s2;

endmodule

// ===== sv/pgfe_delay.sv =====
// Enabled shift-register delay line that keeps side terms aligned with the pipeline.
// No package dependency.
module pgfe_delay #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

// ===== sv/pgfe_obuf.sv =====
// Two-entry output buffer between the pipeline tail and the result channel.
// Depends on pgfe_pkg for the result type and depth.
module pgfe_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pgfe_pkg::res_t din,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output pgfe_pkg::res_t dout
);
	import pgfe_pkg::*;

	localparam int PTR_BITS = $clog2(OBUF_DEPTH);
	localparam int CNT_BITS = $clog2(OBUF_DEPTH + 1);

	res_t                ent_q [OBUF_DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign full      = cnt_q == CNT_BITS'(OBUF_DEPTH);
	assign dout      = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

// ===== sv/phi4_gradient_free_energy_terms.sv =====
// Brazovskii free energy evaluator: energy density, chemical potential and stress
// for one lattice site per request. Depends on pgfe_pkg, pgfe_if, pgfe_mulq,
// pgfe_delay and pgfe_obuf.
//
// Usage:
//   din  carries one site (phi, gradient, Laplacian, bi-Laplacian, gradient of the
//        Laplacian); a request is taken when valid and ready are both high.
//   dout carries the eight results of that site, in request order.
//   cfg  writes coef_a, coef_b, coef_kappa, coef_c by index; it is always ready. The user
//        must write it only while no request is in flight; the block does not enforce it.
// Timing: one request per cycle sustained while the pipeline is not frozen. A result passes
//   through 11 pipeline stages (four levels of two-stage multipliers plus three summing
//   stages) and the output buffer register before it shows on dout.
// Stall: a two-entry output buffer absorbs results while dout is held off; once it
//   is full and the last stage holds a result, the whole pipeline freezes and
//   din.ready drops. Nothing is dropped or repeated.
// Reset: clears the stage valid bits, empties the output buffer and sets all four
//   coefficients to zero.
module phi4_gradient_free_energy_terms #(
	parameter int DATA_BITS = pgfe_pkg::DATA_BITS_DEF,
	parameter int FRAC_BITS = pgfe_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pgfe_in_if.sink    din,
	pgfe_out_if.source dout,
	pgfe_cfg_if.sink   cfg
);
	import pgfe_pkg::*;

	localparam int   NPAIR = 6;
	localparam int   PAIR_I [NPAIR] = '{0, 1, 2, 0, 0, 1};
	localparam int   PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};
	localparam out_t HALF_C    = OUT_BITS'(1) << (FRAC_BITS - 1);
	localparam out_t QUARTER_C = OUT_BITS'(1) << (FRAC_BITS - 2);
	localparam out_t THREEQ_C  = OUT_BITS'(3) << (FRAC_BITS - 2);

	// configuration
	logic signed [DATA_BITS-1:0] coef_a_q;
	logic signed [DATA_BITS-1:0] coef_b_q;
	logic signed [DATA_BITS-1:0] coef_kappa_q;
	logic signed [DATA_BITS-1:0] coef_c_q;
	out_t ca, cb, ck, cc;

	// pipeline control
	logic [PIPE_DEPTH-1:0] vld_s;
	logic                  adv;
	logic                  push;
	logic                  obuf_full;
	logic                  obuf_valid;
	res_t                  res_s11;
	res_t                  res_out;

	// inputs widened
	out_t phi_x, lap_x, b4_x;
	out_t gx [3];
	out_t hx [3];

	// first multiply level
	out_t p2_m, l2_m, pl_m, pb_m, aphi_m, klap_m, cb4_m;
	out_t gg_m [NPAIR];
	out_t gh_m [3][3];

	// stage 3
	out_t p2_s3, l2_s3, pl_s3, pb_s3, g2_s3, gh_s3;
	out_t gg_s3   [NPAIR];
	out_t pair_s3 [NPAIR];
	sum_t r1p_s3;
	out_t phi_d3;

	// second multiply level
	out_t p4_m, p3_m, ap2_m, cl2_m, kg2_m, cgh_m, kpl_m, cpb_m;
	out_t kgg_m [NPAIR];
	out_t cpr_m [NPAIR];

	// stage 6
	out_t [2:0] off_s6;
	sum_t [2:0] dp_s6;
	sum_t       q_s6;
	out_t [2:0] off_d;
	sum_t [2:0] dp_d;
	sum_t       q_d;
	sum_t       r1p_d;

	// third and fourth multiply levels
	out_t bp4_m, bp3_m, at_m, cl_m, kg_m, qb_m, tb_m;
	out_t [3:0] l3_pack;
	out_t [3:0] l3_d;

	// final sums
	out_t res0_s10, res1_s10, p0_s10;
	out_t res0_s11, res1_s11;
	out_t diag_s11 [3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q     <= '0;
			coef_b_q     <= '0;
			coef_kappa_q <= '0;
			coef_c_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COEF_A:     coef_a_q     <= cfg.data;
				REG_COEF_B:     coef_b_q     <= cfg.data;
				REG_COEF_KAPPA: coef_kappa_q <= cfg.data;
				REG_COEF_C:     coef_c_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ca = OUT_BITS'(coef_a_q);
	assign cb = OUT_BITS'(coef_b_q);
	assign ck = OUT_BITS'(coef_kappa_q);
	assign cc = OUT_BITS'(coef_c_q);

	// Freeze every stage only when the tail holds a result the buffer cannot take.
	assign adv       = !vld_s[PIPE_DEPTH-1] || !obuf_full;
	assign din.ready = adv;
	assign push      = vld_s[PIPE_DEPTH-1] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], din.valid};
		end
	end

	assign phi_x = OUT_BITS'(din.phi_value);
	assign lap_x = OUT_BITS'(din.lap_phi);
	assign b4_x  = OUT_BITS'(din.bilap_phi);
	assign gx[0] = OUT_BITS'(din.grad_x);
	assign gx[1] = OUT_BITS'(din.grad_y);
	assign gx[2] = OUT_BITS'(din.grad_z);
	assign hx[0] = OUT_BITS'(din.grad_lap_x);
	assign hx[1] = OUT_BITS'(din.grad_lap_y);
	assign hx[2] = OUT_BITS'(din.grad_lap_z);

	// ---- level 1: products of the raw site values ----
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_p2 (
		.clk, .en(adv), .op_a(phi_x), .op_b(phi_x), .prod(p2_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_l2 (
		.clk, .en(adv), .op_a(lap_x), .op_b(lap_x), .prod(l2_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_pl (
		.clk, .en(adv), .op_a(phi_x), .op_b(lap_x), .prod(pl_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_pb (
		.clk, .en(adv), .op_a(phi_x), .op_b(b4_x), .prod(pb_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_aphi (
		.clk, .en(adv), .op_a(ca), .op_b(phi_x), .prod(aphi_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_klap (
		.clk, .en(adv), .op_a(ck), .op_b(lap_x), .prod(klap_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cb4 (
		.clk, .en(adv), .op_a(cc), .op_b(b4_x), .prod(cb4_m));

	for (genvar k = 0; k < NPAIR; k++) begin : g_gg
		pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul (
			.clk, .en(adv), .op_a(gx[PAIR_I[k]]), .op_b(gx[PAIR_J[k]]), .prod(gg_m[k]));
	end

	for (genvar a = 0; a < 3; a++) begin : g_gh_row
		for (genvar b = 0; b < 3; b++) begin : g_gh_col
			pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul (
				.clk, .en(adv), .op_a(gx[a]), .op_b(hx[b]), .prod(gh_m[a][b]));
		end
	end

	pgfe_delay #(.WIDTH(OUT_BITS), .DEPTH(3)) u_phi_dly (
		.clk, .en(adv), .d(phi_x), .q(phi_d3));

	// ---- stage 3: dot products, symmetric pairs, early part of mu ----
	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s3  <= p2_m;
			l2_s3  <= l2_m;
			pl_s3  <= pl_m;
			pb_s3  <= pb_m;
			g2_s3  <= sat_out(SUM_BITS'(gg_m[0]) + SUM_BITS'(gg_m[1]) + SUM_BITS'(gg_m[2]));
			gh_s3  <= sat_out(SUM_BITS'(gh_m[0][0]) + SUM_BITS'(gh_m[1][1])
				+ SUM_BITS'(gh_m[2][2]));
			r1p_s3 <= SUM_BITS'(aphi_m) - SUM_BITS'(klap_m) + SUM_BITS'(cb4_m);
			for (int k = 0; k < NPAIR; k++) begin
				gg_s3[k]   <= gg_m[k];
				pair_s3[k] <= sat_out(SUM_BITS'(gh_m[PAIR_I[k]][PAIR_J[k]])
					+ SUM_BITS'(gh_m[PAIR_J[k]][PAIR_I[k]]));
			end
		end
	end

	// ---- level 2: coefficient products and higher powers ----
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_p4 (
		.clk, .en(adv), .op_a(p2_s3), .op_b(p2_s3), .prod(p4_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_p3 (
		.clk, .en(adv), .op_a(p2_s3), .op_b(phi_d3), .prod(p3_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_ap2 (
		.clk, .en(adv), .op_a(ca), .op_b(p2_s3), .prod(ap2_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cl2 (
		.clk, .en(adv), .op_a(cc), .op_b(l2_s3), .prod(cl2_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_kg2 (
		.clk, .en(adv), .op_a(ck), .op_b(g2_s3), .prod(kg2_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cgh (
		.clk, .en(adv), .op_a(cc), .op_b(gh_s3), .prod(cgh_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_kpl (
		.clk, .en(adv), .op_a(ck), .op_b(pl_s3), .prod(kpl_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cpb (
		.clk, .en(adv), .op_a(cc), .op_b(pb_s3), .prod(cpb_m));

	for (genvar k = 0; k < NPAIR; k++) begin : g_stress_terms
		pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_kgg (
			.clk, .en(adv), .op_a(ck), .op_b(gg_s3[k]), .prod(kgg_m[k]));
		pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cpr (
			.clk, .en(adv), .op_a(cc), .op_b(pair_s3[k]), .prod(cpr_m[k]));
	end

	pgfe_delay #(.WIDTH(SUM_BITS), .DEPTH(6)) u_r1p_dly (
		.clk, .en(adv), .d(r1p_s3), .q(r1p_d));

	// ---- stage 6: off-diagonal stress done; diagonal and p0 partials kept exact ----
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				off_s6[k] <= sat_out(SUM_BITS'(kgg_m[k+3]) - SUM_BITS'(cpr_m[k+3]));
				dp_s6[k]  <= SUM_BITS'(kgg_m[k]) - SUM_BITS'(cpr_m[k]);
			end
			q_s6 <= SUM_BITS'(cgh_m) + SUM_BITS'(cpb_m) - SUM_BITS'(kpl_m);
		end
	end

	pgfe_delay #(.WIDTH(3 * OUT_BITS), .DEPTH(5)) u_off_dly (
		.clk, .en(adv), .d(off_s6), .q(off_d));
	pgfe_delay #(.WIDTH(3 * SUM_BITS), .DEPTH(4)) u_dp_dly (
		.clk, .en(adv), .d(dp_s6), .q(dp_d));
	pgfe_delay #(.WIDTH(SUM_BITS), .DEPTH(3)) u_q_dly (
		.clk, .en(adv), .d(q_s6), .q(q_d));

	// ---- level 3: quartic and cubic b terms, halved terms ----
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_bp4 (
		.clk, .en(adv), .op_a(cb), .op_b(p4_m), .prod(bp4_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_bp3 (
		.clk, .en(adv), .op_a(cb), .op_b(p3_m), .prod(bp3_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_at (
		.clk, .en(adv), .op_a(HALF_C), .op_b(ap2_m), .prod(at_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_cl (
		.clk, .en(adv), .op_a(HALF_C), .op_b(cl2_m), .prod(cl_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_kg (
		.clk, .en(adv), .op_a(HALF_C), .op_b(kg2_m), .prod(kg_m));

	// ---- level 4: quarter and three-quarter scaling of b phi^4 ----
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_qb (
		.clk, .en(adv), .op_a(QUARTER_C), .op_b(bp4_m), .prod(qb_m));
	pgfe_mulq #(.FRAC_BITS(FRAC_BITS)) u_tb (
		.clk, .en(adv), .op_a(THREEQ_C), .op_b(bp4_m), .prod(tb_m));

	assign l3_pack = {at_m, cl_m, kg_m, bp3_m};

	pgfe_delay #(.WIDTH(4 * OUT_BITS), .DEPTH(2)) u_l3_dly (
		.clk, .en(adv), .d(l3_pack), .q(l3_d));

	// ---- stage 10: f, mu and the isotropic pressure ----
	always_ff @(posedge clk) begin
		if (adv) begin
			res0_s10 <= sat_out(SUM_BITS'(l3_d[3]) + SUM_BITS'(qb_m) + SUM_BITS'(l3_d[1])
				+ SUM_BITS'(l3_d[2]));
			res1_s10 <= sat_out(r1p_d + SUM_BITS'(l3_d[0]));
			p0_s10   <= sat_out(SUM_BITS'(l3_d[3]) + SUM_BITS'(tb_m) + SUM_BITS'(l3_d[1])
				+ SUM_BITS'(l3_d[2]) + q_d);
		end
	end

	// ---- stage 11: add pressure onto the diagonal ----
	always_ff @(posedge clk) begin
		if (adv) begin
			res0_s11 <= res0_s10;
			res1_s11 <= res1_s10;
			for (int k = 0; k < 3; k++) begin
				diag_s11[k] <= sat_out(SUM_BITS'(p0_s10) + dp_d[k]);
			end
		end
	end

	assign res_s11 = '{
		free_energy_density: res0_s11,
		chemical_potential:  res1_s11,
		stress_xx:           diag_s11[0],
		stress_yy:           diag_s11[1],
		stress_zz:           diag_s11[2],
		stress_xy:           off_d[0],
		stress_xz:           off_d[1],
		stress_yz:           off_d[2]
	};

	pgfe_obuf u_obuf (
		.clk,
		.arst_n,
		.push,
		.din       (res_s11),
		.full      (obuf_full),
		.out_valid (obuf_valid),
		.out_ready (dout.ready),
		.dout      (res_out)
	);

	assign dout.valid               = obuf_valid;
	assign dout.free_energy_density = res_out.free_energy_density;
	assign dout.chemical_potential  = res_out.chemical_potential;
	assign dout.stress_xx           = res_out.stress_xx;
	assign dout.stress_yy           = res_out.stress_yy;
	assign dout.stress_zz           = res_out.stress_zz;
	assign dout.stress_xy           = res_out.stress_xy;
	assign dout.stress_xz           = res_out.stress_xz;
	assign dout.stress_yz           = res_out.stress_yz;

endmodule

// ===== sv/pgfe_chk.sv =====
// Port-level checker for the free energy block, attached by bind below.
// Depends on pgfe_pkg for pipeline and buffer depths.
module pgfe_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pgfe_pkg::RES_BITS-1:0] out_bits
);
	import pgfe_pkg::*;

	localparam int PEND_BITS = 8;

	logic [PEND_BITS-1:0] pend_q;
	logic                 in_acc;
	logic                 out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_BITS'(in_acc) - PEND_BITS'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_bits))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result offered with no request outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_BITS'(PIPE_DEPTH + OBUF_DEPTH))
		else $error("more requests in flight than the pipeline can hold");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("requests refused while no result is pending");

endmodule

bind phi4_gradient_free_energy_terms pgfe_chk u_pgfe_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_bits  ({dout.free_energy_density, dout.chemical_potential, dout.stress_xx,
		dout.stress_yy, dout.stress_zz, dout.stress_xy, dout.stress_xz, dout.stress_yz})
);
